### rtl/core/emap_pkg.sv
// Package for the extent map: command, response and table entry types,
// item kind and status codes, controller states. No dependencies.
package emap_pkg;

	localparam int unsigned WORD_W = 64;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] run_length;
		logic [WORD_W-1:0] run_start;
		logic              run_sparse;
		logic [WORD_W-1:0] virtual_cluster;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] physical_cluster;
		logic              hole;
		logic [WORD_W-1:0] clusters_left;
		logic [WORD_W-1:0] cluster_total;
	} rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0] start;
		logic [WORD_W-1:0] length;
		logic              hole;
	} extent_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

endpackage

### rtl/core/extent_map_vcn_to_lcn.sv
// Extent map top level: extent table memory, append/clear handling and the
// sequential lookup walk. Depends on emap_pkg.
//
// Usage:
//   Command channel: drive cmd and raise start; the transfer happens at a
//   rising edge where start is high and busy is low. kind selects append,
//   lookup or clear (the unused kind does nothing and reports ok).
//   Response channel: done pulses for exactly one cycle with rsp valid. The
//   receiver cannot stall; each command yields exactly one response.
// Throughput and walk:
//   Append, clear and the unused kind answer in the cycle after the transfer,
//   and busy stays low, so one such command is taken every cycle.
//   A lookup walks the table one entry per cycle through the single read
//   port of the extent memory (registered read data). On a hit at the
//   covering extent the controller passes through ST_FINISH before done;
//   a miss answers after the last stored extent, an empty table in the
//   cycle after the transfer. busy is high for the whole walk, so no new
//   command is taken until the lookup is answered.
// Reset:
//   arst_n clears the extent count, the running total and the controller.
//   The memory is not cleared; only entries below the count are ever used.
module extent_map_vcn_to_lcn #(
	parameter int unsigned MAX_EXTENTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  emap_pkg::cmd_t  cmd,
	output logic            done,
	output emap_pkg::rsp_t  rsp
);
	import emap_pkg::*;

	localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_EXTENTS);

	// extent table
	extent_t mem [MAX_EXTENTS];
	extent_t rd_q;
	logic    wr_en;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;

	// control state
	state_t state_q, state_nxt;
	logic [CW-1:0] count_q;
	logic [WORD_W-1:0] total_q;
	logic [CW-1:0] chk_q;       // entry whose data sits in rd_q during the walk
	logic done_q;

	// walk datapath
	logic [WORD_W-1:0] rem_q;   // virtual cluster minus the lengths passed so far
	extent_t           hit_q;
	logic [WORD_W-1:0] hit_rem_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              full;
	logic [WORD_W:0]   sum;
	logic [WORD_W:0]   diff;
	logic              walk_hit;
	logic              walk_last;
	logic [CW-1:0]     chk_plus;
	logic              reply_now;
	rsp_t              imm_rsp;

	assign accept    = start && (state_q == ST_IDLE);
	assign full      = (count_q == COUNT_MAX);
	assign sum       = {1'b0, total_q} + {1'b0, cmd.run_length};
	assign diff      = {1'b0, rem_q} - {1'b0, rd_q.length};
	assign walk_hit  = diff[WORD_W];   // borrow: remaining offset lies in this run
	assign chk_plus  = chk_q + CW'(1);
	assign walk_last = (chk_plus == count_q);
	assign wr_en     = accept && (cmd.kind == KIND_APPEND) && !full;
	assign wr_addr   = count_q[IW-1:0];

	// answer next cycle: a quick command, a miss on the last entry, or a finished hit
	assign reply_now = (accept && ((cmd.kind != KIND_LOOKUP) || (count_q == '0)))
		|| ((state_q == ST_WALK) && !walk_hit && walk_last)
		|| (state_q == ST_FINISH);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.kind == KIND_LOOKUP) && (count_q != '0))
					state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (walk_hit)
					state_nxt = ST_FINISH;
				else if (walk_last)
					state_nxt = ST_IDLE;
			end
			ST_FINISH: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		busy    = 1'b1;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				rd_addr = '0;            // prefetch the first extent
			end
			ST_WALK:   rd_addr = chk_plus[IW-1:0];
			ST_FINISH: rd_addr = '0;
			default:   rd_addr = '0;
		endcase
	end

	// response for commands answered straight from the transfer cycle
	always_comb begin
		imm_rsp               = '0;
		imm_rsp.cluster_total = total_q;
		case (cmd.kind)
			KIND_APPEND: begin
				if (full) begin
					imm_rsp.status = STATUS_FULL;
				end else if (sum[WORD_W]) begin
					imm_rsp.status = STATUS_OVERFLOW;
				end else begin
					imm_rsp.cluster_total = sum[WORD_W-1:0];
				end
			end
			KIND_LOOKUP: imm_rsp.status = STATUS_NOT_FOUND;   // empty table only
			KIND_CLEAR:  imm_rsp.cluster_total = '0;
			default:     imm_rsp.status = STATUS_OK;
		endcase
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= '{start: cmd.run_start, length: cmd.run_length,
				hole: cmd.run_sparse};
		rd_q <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			total_q <= '0;
			chk_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= reply_now;
			case (state_q)
				ST_IDLE: begin
					chk_q <= '0;
					if (accept) begin
						case (cmd.kind)
							KIND_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
									if (!sum[WORD_W])
										total_q <= sum[WORD_W-1:0];
								end
							end
							KIND_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							default: count_q <= count_q;
						endcase
					end
				end
				ST_WALK: chk_q <= chk_plus;
				default: chk_q <= chk_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q <= cmd.virtual_cluster;
				if (accept)
					rsp_q <= imm_rsp;
			end
			ST_WALK: begin
				rem_q     <= diff[WORD_W-1:0];
				hit_q     <= rd_q;
				hit_rem_q <= rem_q;
				// a miss on the last entry answers now
				if (!walk_hit && walk_last)
					rsp_q <= '{status: STATUS_NOT_FOUND, physical_cluster: '0,
						hole: 1'b0, clusters_left: '0, cluster_total: total_q};
			end
			ST_FINISH: begin
				rsp_q <= '{status: STATUS_OK,
					physical_cluster: hit_q.hole ? '0 : hit_q.start + hit_rem_q,
					hole: hit_q.hole,
					clusters_left: hit_q.length - hit_rem_q,
					cluster_total: total_q};
			end
			default: rem_q <= rem_q;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("extent count beyond table depth");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (chk_q < count_q))
		else $error("lookup walk past the stored extents");

	a_quick_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.kind != KIND_LOOKUP)) |=> done)
		else $error("non-lookup command not answered in one cycle");

	a_full_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == STATUS_FULL)) |-> full)
		else $error("table full reported with room left");
`endif

endmodule

### tb/testbench.sv
// Self-checking bench for extent_map_vcn_to_lcn: directed and random append, lookup and
// clear commands, with results predicted by an in-bench extent table.
// Depends on emap_pkg and the extent_map_vcn_to_lcn RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import emap_pkg::*;

	localparam int unsigned EXTENT_SLOTS = 64;
	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned REPORT_CAP   = 40;

	// The package names three kinds; the fourth code is a no-op.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	cmd_t cmd;
	rsp_t rsp;

	extent_map_vcn_to_lcn #(
		.MAX_EXTENTS(EXTENT_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	// Commands waiting to be driven, and results waiting to be seen.
	cmd_t pending_cmd_q[$];
	rsp_t expected_rsp_q[$];

	// Predicted extent table: base cluster, length and sparse mark per slot.
	logic [WORD_W-1:0] ext_base[EXTENT_SLOTS];
	logic [WORD_W-1:0] ext_len[EXTENT_SLOTS];
	logic              ext_sparse[EXTENT_SLOTS];
	int unsigned       ext_n;
	logic [WORD_W-1:0] cluster_sum;

	// Lengths of the extents the generator expects to be stored, for aiming lookups.
	logic [WORD_W-1:0] planned_len_q[$];

	int unsigned error_count;
	int unsigned xfer_count;
	int unsigned rsp_count;
	int unsigned idle_cycles;
	logic        taken;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		taken = 1'b0;
		ext_n = 0;
		cluster_sum = '0;
		error_count = 0;
		xfer_count = 0;
		rsp_count = 0;
		idle_cycles = 0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report(input string msg);
		if (error_count < REPORT_CAP)
			$display("mismatch at response %0d: %s", rsp_count, msg);
		error_count++;
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Sum of planned lengths below slot upto, wrapping modulo 2**WORD_W.
	function automatic logic [WORD_W-1:0] planned_sum(input int upto);
		logic [WORD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < upto; i++)
			acc += planned_len_q[i];
		return acc;
	endfunction

	// Queue one command and track what the table should hold afterwards.
	task automatic queue_cmd(input logic [1:0] k, input logic [WORD_W-1:0] len,
			input logic [WORD_W-1:0] base, input logic sparse,
			input logic [WORD_W-1:0] vcn);
		cmd_t c;
		c.kind = k;
		c.run_length = len;
		c.run_start = base;
		c.run_sparse = sparse;
		c.virtual_cluster = vcn;
		pending_cmd_q.push_back(c);
		if (k == KIND_APPEND && planned_len_q.size() < EXTENT_SLOTS)
			planned_len_q.push_back(len);
		else if (k == KIND_CLEAR)
			planned_len_q.delete();
	endtask

	// Apply one command to the predicted table and return the result it must produce.
	function automatic rsp_t map_translate(input cmd_t c);
		rsp_t r;
		logic [WORD_W-1:0] walked;
		logic [WORD_W-1:0] offset;
		logic hit;
		r = '0;
		r.status = STATUS_OK;
		case (c.kind)
			KIND_APPEND: begin
				if (ext_n >= EXTENT_SLOTS) begin
					r.status = STATUS_FULL;
				end else begin
					ext_len[ext_n] = c.run_length;
					ext_base[ext_n] = c.run_start;
					ext_sparse[ext_n] = c.run_sparse;
					ext_n++;
					// Keep the extent but hold the total when it would wrap.
					if (cluster_sum > ~c.run_length)
						r.status = STATUS_OVERFLOW;
					else
						cluster_sum += c.run_length;
				end
			end
			KIND_LOOKUP: begin
				r.status = STATUS_NOT_FOUND;
				walked = '0;
				hit = 1'b0;
				// Compare the remaining distance, so the walked sum never wraps;
				// empty extents are skipped naturally.
				for (int i = 0; i < ext_n && !hit; i++) begin
					offset = c.virtual_cluster - walked;
					if (offset < ext_len[i]) begin
						hit = 1'b1;
						r.status = STATUS_OK;
						r.hole = ext_sparse[i];
						r.physical_cluster = ext_sparse[i] ? '0 : ext_base[i] + offset;
						r.clusters_left = ext_len[i] - offset;
					end else begin
						walked += ext_len[i];
					end
				end
			end
			KIND_CLEAR: begin
				ext_n = 0;
				cluster_sum = '0;
			end
			default: ;
		endcase
		r.cluster_total = cluster_sum;
		return r;
	endfunction

	// Monitor: check results, log transfers into the prediction, and run the watchdog.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			// Check before logging a new transfer: a result always belongs to
			// an earlier transfer.
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					report("result with no transfer waiting");
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report($sformatf("status %0d, want %0d", rsp.status, want.status));
					if (rsp.physical_cluster !== want.physical_cluster)
						report($sformatf("physical_cluster %h, want %h",
							rsp.physical_cluster, want.physical_cluster));
					if (rsp.hole !== want.hole)
						report($sformatf("hole %b, want %b", rsp.hole, want.hole));
					if (rsp.clusters_left !== want.clusters_left)
						report($sformatf("clusters_left %h, want %h",
							rsp.clusters_left, want.clusters_left));
					if (rsp.cluster_total !== want.cluster_total)
						report($sformatf("cluster_total %h, want %h",
							rsp.cluster_total, want.cluster_total));
				end
				rsp_count++;
			end
			if (start && !busy) begin
				expected_rsp_q.push_back(map_translate(cmd));
				xfer_count++;
			end
			// Count cycles with no transfer on either side; a long lookup
			// walk plus a sender gap stays far below the limit.
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
			taken <= start && !busy;
		end else begin
			taken <= 1'b0;
		end
	end

	// Driver: present commands in bursts separated by random gaps; hold a
	// command until it transfers, then advance at the falling edge.
	always @(negedge clk) begin
		int unsigned burst_left;
		int unsigned gap_left;
		logic [223:0] noise;
		cmd_t junk;
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (start && !taken) begin
			// hold the current command
		end else if (gap_left > 0 || pending_cmd_q.size() == 0) begin
			// Idle: drop start and scramble the payload, which must be ignored.
			if (gap_left > 0)
				gap_left--;
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			junk = noise[$bits(cmd_t)-1:0];
			start <= 1'b0;
			cmd <= junk;
		end else begin
			cmd <= pending_cmd_q.pop_front();
			start <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				// Mostly short bursts; now and then a long stretch with no gap.
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 8);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int unsigned n_app;
		int unsigned n_look;
		int unsigned pick;
		int unsigned k;
		logic [WORD_W-1:0] len;
		logic [WORD_W-1:0] vcn;
		logic [1:0] noise_kind;

		// Directed: empty table, no-op kind, zero-length extent, base wrap,
		// sparse extent, total reaching the top, overflow, then lookups into the
		// stored extents, the no-op kind again, clear, lookup after clear.
		queue_cmd(KIND_LOOKUP, rand_word(), rand_word(), 1'b1, '0);
		queue_cmd(KIND_SPARE, rand_word(), rand_word(), 1'b1, rand_word());
		queue_cmd(KIND_APPEND, '0, '1, 1'b0, '0);
		queue_cmd(KIND_APPEND, 64'd10, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, '1);
		queue_cmd(KIND_APPEND, 64'd5, 64'h0000_0000_0000_1234, 1'b1, '0);
		queue_cmd(KIND_APPEND, ~64'd15, '0, 1'b0, '0);
		queue_cmd(KIND_APPEND, 64'd1, 64'h0000_0000_0000_0077, 1'b0, '0);
		queue_cmd(KIND_LOOKUP, '0, '0, 1'b0, 64'd0);
		queue_cmd(KIND_LOOKUP, '0, '0, 1'b0, 64'd9);
		queue_cmd(KIND_LOOKUP, '0, '0, 1'b0, 64'd12);
		queue_cmd(KIND_LOOKUP, '0, '0, 1'b0, 64'd15);
		queue_cmd(KIND_LOOKUP, '0, '0, 1'b0, 64'd20);
		queue_cmd(KIND_LOOKUP, '1, '1, 1'b1, '1);
		queue_cmd(KIND_LOOKUP, '0, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE);
		queue_cmd(KIND_SPARE, '0, '0, 1'b0, '0);
		queue_cmd(KIND_CLEAR, '1, '1, 1'b1, '1);
		queue_cmd(KIND_LOOKUP, '0, '0, 1'b0, 64'd0);

		// Random: mostly build-then-translate sequences, with some noise.
		while (pending_cmd_q.size() < RANDOM_ITEMS + 17) begin
			if ($urandom_range(0, 9) != 0)
				queue_cmd(KIND_CLEAR, rand_word(), rand_word(), 1'($urandom_range(0, 1)),
					rand_word());
			pick = $urandom_range(0, 9);
			n_app = (pick < 7) ? $urandom_range(0, 8)
				: (pick < 9) ? $urandom_range(9, 40) : $urandom_range(60, 70);
			for (int a = 0; a < n_app; a++) begin
				pick = $urandom_range(0, 9);
				len = (pick < 6) ? WORD_W'($urandom_range(1, 64))
					: (pick < 7) ? '0
					: (pick < 9) ? {32'd0, $urandom} : rand_word();
				queue_cmd(KIND_APPEND, len, rand_word(), ($urandom_range(0, 3) == 0),
					rand_word());
			end
			n_look = $urandom_range(1, 8);
			for (int l = 0; l < n_look; l++) begin
				pick = $urandom_range(0, 99);
				if (planned_len_q.size() > 0 && pick < 60) begin
					// Aim inside a chosen extent.
					k = $urandom_range(0, planned_len_q.size() - 1);
					vcn = planned_sum(k);
					if (planned_len_q[k] != '0)
						vcn += rand_word() % planned_len_q[k];
				end else if (pick < 75) begin
					// Just past the end, or the last cluster.
					vcn = planned_sum(planned_len_q.size()) - WORD_W'($urandom_range(0, 1));
				end else begin
					vcn = rand_word();
				end
				queue_cmd(KIND_LOOKUP, rand_word(), rand_word(), 1'($urandom_range(0, 1)),
					vcn);
			end
			// Noise: no-op kind, or a stray lookup or clear mid-sequence.
			if ($urandom_range(0, 4) == 0) begin
				noise_kind = $urandom_range(0, 2) == 0 ? KIND_CLEAR
					: ($urandom_range(0, 1) == 0 ? KIND_LOOKUP : KIND_SPARE);
				queue_cmd(noise_kind, rand_word(), rand_word(), 1'($urandom_range(0, 1)),
					rand_word());
			end
		end
		pick = pending_cmd_q.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every command has transferred and every result arrived,
		// then give the block a full walk's time to show anything stray.
		do
			@(negedge clk);
		while (xfer_count < pick || expected_rsp_q.size() != 0);
		repeat (EXTENT_SLOTS + 8) @(negedge clk);

		if (expected_rsp_q.size() != 0)
			report($sformatf("%0d results never arrived", expected_rsp_q.size()));
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/emap_pkg.sv
rtl/core/extent_map_vcn_to_lcn.sv
tb/testbench.sv
